@@ rtl/core/assert_macros.svh @@
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/tel_pkg.sv @@
package tel_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_WEIGHT = 2'd0,
      OP_WRITE_POS    = 2'd1,
      OP_LOOKUP       = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      CSR_VOCAB_COUNT     = 3'd0,
      CSR_SEQ_LENGTH      = 3'd1,
      CSR_EMBED_WIDTH     = 3'd2,
      CSR_SCALE_ENABLE    = 3'd3,
      CSR_POSITION_ENABLE = 3'd4,
      CSR_SCALE_FACTOR    = 3'd5
   } csr_index_type;

   localparam logic [12:0] RST_VOCAB_COUNT  = 13'd4096;
   localparam logic [10:0] RST_SEQ_LENGTH   = 11'd1024;
   localparam logic [6:0]  RST_EMBED_WIDTH  = 7'd64;
   localparam logic [15:0] RST_SCALE_FACTOR = 16'd2048;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] row;
      logic [5:0]         column;
      logic signed [15:0] value;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [15:0] element;
      logic [5:0]         element_index;
      logic               last;
      logic               zeroed;
      logic               out_of_range;
   } rsp_type;

   // per-beat tags carried down the read pipeline
   typedef struct packed {
      logic [5:0] index;
      logic       last;
      logic       zeroed;
      logic       out_of_range;
   } beat_meta_type;

endpackage

@@ rtl/core/tel_ram.sv @@
module tel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/token_embedding_lookup_core.sv @@
// channel | dir | handshake              | beat
// req     | in  | req_valid / req_ready  | req_type: table write or token lookup
// rsp     | out | rsp_valid / rsp_ready  | rsp_type: one embedding element
// csr     | in  | APB psel/penable       | 32-bit register write/read, pready tied high
//
// A table write gives no beat. A lookup gives
// clamp(embed_width, 1, EMBED_MAX) beats, one per cycle unless rsp_ready stalls;
// the next item is taken in the cycle the last element read issues. Each
// table RAM has a single read port.
// First beat path after the lookup: busy/address regs, RAM read, product, round/add into rsp reg.
// Reset (synchronous) sets CSR defaults and clears busy/valid/count; datapath regs and table RAMs are not reset.
// A stalled rsp_ready freezes the whole read pipeline, RAM outputs included.
`include "assert_macros.svh"

module token_embedding_lookup_core
   import tel_pkg::*;
#(
   parameter int VOCAB_DEPTH = 4096,
   parameter int EMBED_MAX   = 64,
   parameter int SEQ_MAX     = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_W   = (EMBED_MAX > 1) ? $clog2(EMBED_MAX) : 1;
   localparam int PC_W    = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1;
   localparam int W_DEPTH = VOCAB_DEPTH * EMBED_MAX;
   localparam int P_DEPTH = SEQ_MAX * EMBED_MAX;
   localparam int WAW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int PAW     = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;

   // ---------------- configuration registers ----------------
   logic [12:0] vocab_count_ff,  vocab_count_in;
   logic [10:0] seq_length_ff,   seq_length_in;
   logic [6:0]  embed_width_ff,  embed_width_in;
   logic        scale_enable_ff, scale_enable_in;
   logic        pos_enable_ff,   pos_enable_in;
   logic [15:0] scale_factor_ff, scale_factor_in;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      vocab_count_in  = vocab_count_ff;
      seq_length_in   = seq_length_ff;
      embed_width_in  = embed_width_ff;
      scale_enable_in = scale_enable_ff;
      pos_enable_in   = pos_enable_ff;
      scale_factor_in = scale_factor_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            CSR_VOCAB_COUNT:     vocab_count_in  = csr_pwdata[12:0];
            CSR_SEQ_LENGTH:      seq_length_in   = csr_pwdata[10:0];
            CSR_EMBED_WIDTH:     embed_width_in  = csr_pwdata[6:0];
            CSR_SCALE_ENABLE:    scale_enable_in = csr_pwdata[0];
            CSR_POSITION_ENABLE: pos_enable_in   = csr_pwdata[0];
            CSR_SCALE_FACTOR:    scale_factor_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         CSR_VOCAB_COUNT:     csr_prdata = {19'd0, vocab_count_ff};
         CSR_SEQ_LENGTH:      csr_prdata = {21'd0, seq_length_ff};
         CSR_EMBED_WIDTH:     csr_prdata = {25'd0, embed_width_ff};
         CSR_SCALE_ENABLE:    csr_prdata = {31'd0, scale_enable_ff};
         CSR_POSITION_ENABLE: csr_prdata = {31'd0, pos_enable_ff};
         CSR_SCALE_FACTOR:    csr_prdata = {16'd0, scale_factor_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // ---------------- request decode ----------------
   logic        req_fire;
   logic [15:0] row_u;
   logic        col_ok;
   logic        w_wr_en, p_wr_en;
   logic [WAW-1:0] w_wr_addr;
   logic [PAW-1:0] p_wr_addr;
   logic        is_lookup;

   assign req_fire = req_valid && req_ready;
   assign row_u    = req_payload.row;
   assign col_ok   = {1'b0, req_payload.column} < 7'(EMBED_MAX);

   assign w_wr_en = req_fire && (req_payload.operation == OP_WRITE_WEIGHT) && !row_u[15]
                    && (row_u < 16'(VOCAB_DEPTH)) && col_ok;
   assign p_wr_en = req_fire && (req_payload.operation == OP_WRITE_POS) && !row_u[15]
                    && (row_u < 16'(SEQ_MAX)) && col_ok;
   assign w_wr_addr = WAW'(32'(row_u[14:0]) * 32'(EMBED_MAX) + 32'(req_payload.column));
   assign p_wr_addr = PAW'(32'(row_u[14:0]) * 32'(EMBED_MAX) + 32'(req_payload.column));
   assign is_lookup = req_fire && (req_payload.operation == OP_LOOKUP);

   // lookup limits, token class and position for the accepted lookup
   logic [15:0]      lim_v, lim_s, vocab16, seq16;
   logic [15:0]      pos16, next16;
   logic             row_zeroed, row_oor;
   logic [COL_W-1:0] last_idx;
   logic [PC_W-1:0]  count_ff, count_in;

   assign vocab16 = {3'd0, vocab_count_ff};
   assign seq16   = {5'd0, seq_length_ff};
   assign lim_v   = (vocab16 < 16'(VOCAB_DEPTH)) ? vocab16 : 16'(VOCAB_DEPTH);

   always_comb begin
      if (seq16 == 16'd0) begin
         lim_s = 16'd1;
      end else if (seq16 > 16'(SEQ_MAX)) begin
         lim_s = 16'(SEQ_MAX);
      end else begin
         lim_s = seq16;
      end
      pos16 = req_payload.restart ? 16'd0 : 16'(count_ff);
      if (pos16 >= lim_s) begin
         pos16 = 16'd0;
      end
      next16 = pos16 + 16'd1;
      if (next16 >= lim_s) begin
         next16 = 16'd0;
      end
   end

   // padding id zero is never out of range, even with an empty vocabulary
   assign row_oor    = (row_u != 16'd0) && (row_u[15] || (row_u >= lim_v));
   assign row_zeroed = (row_u == 16'd0) || row_oor;

   always_comb begin
      if (embed_width_ff == 7'd0) begin
         last_idx = '0;
      end else if (embed_width_ff > 7'(EMBED_MAX)) begin
         last_idx = COL_W'(EMBED_MAX - 1);
      end else begin
         last_idx = COL_W'(embed_width_ff - 7'd1);
      end
   end

   // ---------------- read sequencer ----------------
   logic             busy_ff, busy_in;
   logic [COL_W-1:0] j_ff, j_in;
   logic [COL_W-1:0] last_idx_ff, last_idx_in;
   logic             zeroed_ff, zeroed_in;
   logic             oor_ff, oor_in;
   logic [WAW-1:0]   w_raddr_ff, w_raddr_in;
   logic [PAW-1:0]   p_raddr_ff, p_raddr_in;
   logic             adv, issue, issue_last;
   logic             rsp_valid_ff, rsp_valid_in;

   assign adv        = !rsp_valid_ff || rsp_ready;   // pipeline moves unless output holds
   assign issue      = busy_ff && adv;
   assign issue_last = issue && (j_ff == last_idx_ff);
   assign req_ready  = !busy_ff || issue_last;

   always_comb begin
      busy_in     = busy_ff;
      j_in        = j_ff;
      last_idx_in = last_idx_ff;
      zeroed_in   = zeroed_ff;
      oor_in      = oor_ff;
      w_raddr_in  = w_raddr_ff;
      p_raddr_in  = p_raddr_ff;
      count_in    = count_ff;
      if (issue) begin
         j_in       = j_ff + COL_W'(1);
         w_raddr_in = w_raddr_ff + WAW'(1);
         p_raddr_in = p_raddr_ff + PAW'(1);
         if (issue_last) begin
            busy_in = 1'b0;
         end
      end
      if (is_lookup) begin
         busy_in     = 1'b1;
         j_in        = '0;
         last_idx_in = last_idx;
         zeroed_in   = row_zeroed;
         oor_in      = row_oor;
         w_raddr_in  = WAW'(32'(row_u[14:0]) * 32'(EMBED_MAX));
         p_raddr_in  = PAW'(32'(pos16) * 32'(EMBED_MAX));
         count_in    = PC_W'(next16);
      end
   end

   // ---------------- table memories ----------------
   logic [15:0] w_q, p_q;

   tel_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (issue),
      .rd_addr (w_raddr_ff),
      .rd_data (w_q)
   );

   tel_ram #(.WIDTH(16), .DEPTH(P_DEPTH)) u_position_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (p_wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (issue),
      .rd_addr (p_raddr_ff),
      .rd_data (p_q)
   );

   // ---------------- element pipeline ----------------
   // s1: RAM data valid. s2: product registered. then round, add, saturate.
   logic               s1_valid_ff, s1_valid_in;
   beat_meta_type      s1_meta_ff, s1_meta_in;
   logic               s2_valid_ff, s2_valid_in;
   beat_meta_type      s2_meta_ff, s2_meta_in;
   logic signed [31:0] s2_prod_ff, s2_prod_in;
   logic signed [15:0] s2_w_ff, s2_w_in;
   logic signed [15:0] s2_p_ff, s2_p_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [16:0] sf_s;
   logic signed [32:0] prod_full;
   logic signed [31:0] rounded;
   logic signed [15:0] scaled, base_e, elem;
   logic signed [16:0] sum17;

   assign sf_s      = {1'b0, scale_factor_ff};
   assign prod_full = $signed(w_q) * sf_s;

   always_comb begin
      // floor((p + 128) / 256), then clamp to Q7.8
      rounded = (s2_prod_ff + 32'sd128) >>> 8;
      if (rounded > 32'sd32767) begin
         scaled = 16'sh7fff;
      end else if (rounded < -32'sd32768) begin
         scaled = 16'sh8000;
      end else begin
         scaled = rounded[15:0];
      end
      base_e = scale_enable_ff ? scaled : s2_w_ff;
      sum17  = 17'(base_e) + 17'(s2_p_ff);
      if (!pos_enable_ff) begin
         elem = base_e;
      end else if (sum17 > 17'sd32767) begin
         elem = 16'sh7fff;
      end else if (sum17 < -17'sd32768) begin
         elem = 16'sh8000;
      end else begin
         elem = sum17[15:0];
      end
      if (s2_meta_ff.zeroed) begin
         elem = '0;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_meta_in   = s1_meta_ff;
      s2_valid_in  = s2_valid_ff;
      s2_meta_in   = s2_meta_ff;
      s2_prod_in   = s2_prod_ff;
      s2_w_in      = s2_w_ff;
      s2_p_in      = s2_p_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (adv) begin
         s1_valid_in  = issue;
         s2_valid_in  = s1_valid_ff;
         rsp_valid_in = s2_valid_ff;
         if (issue) begin
            s1_meta_in.index        = 6'(j_ff);
            s1_meta_in.last         = (j_ff == last_idx_ff);
            s1_meta_in.zeroed       = zeroed_ff;
            s1_meta_in.out_of_range = oor_ff;
         end
         if (s1_valid_ff) begin
            s2_meta_in = s1_meta_ff;
            s2_prod_in = prod_full[31:0];
            s2_w_in    = w_q;
            s2_p_in    = p_q;
         end
         if (s2_valid_ff) begin
            rsp_data_in.element       = elem;
            rsp_data_in.element_index = s2_meta_ff.index;
            rsp_data_in.last          = s2_meta_ff.last;
            rsp_data_in.zeroed        = s2_meta_ff.zeroed;
            rsp_data_in.out_of_range  = s2_meta_ff.out_of_range;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vocab_count_ff  <= RST_VOCAB_COUNT;
         seq_length_ff   <= RST_SEQ_LENGTH;
         embed_width_ff  <= RST_EMBED_WIDTH;
         scale_enable_ff <= 1'b0;
         pos_enable_ff   <= 1'b0;
         scale_factor_ff <= RST_SCALE_FACTOR;
         busy_ff         <= 1'b0;
         count_ff        <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vocab_count_ff  <= vocab_count_in;
         seq_length_ff   <= seq_length_in;
         embed_width_ff  <= embed_width_in;
         scale_enable_ff <= scale_enable_in;
         pos_enable_ff   <= pos_enable_in;
         scale_factor_ff <= scale_factor_in;
         busy_ff         <= busy_in;
         count_ff        <= count_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      j_ff        <= j_in;
      last_idx_ff <= last_idx_in;
      zeroed_ff   <= zeroed_in;
      oor_ff      <= oor_in;
      w_raddr_ff  <= w_raddr_in;
      p_raddr_ff  <= p_raddr_in;
      s1_meta_ff  <= s1_meta_in;
      s2_meta_ff  <= s2_meta_in;
      s2_prod_ff  <= s2_prod_in;
      s2_w_ff     <= s2_w_in;
      s2_p_ff     <= s2_p_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- assertions ----------------
   `ASSERT_NEXT(a_lookup_starts, clock, reset, is_lookup, busy_ff)
   `ASSERT_IMPLIES(a_issue_in_row, clock, reset, issue, j_ff <= last_idx_ff)
   `ASSERT_IMPLIES(a_zeroed_elem, clock, reset, rsp_valid && rsp_payload.zeroed, rsp_payload.element == 16'sd0)
   `ASSERT_IMPLIES(a_oor_zeroed, clock, reset, rsp_valid && rsp_payload.out_of_range, rsp_payload.zeroed)

endmodule
